### design/pla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pla_pkg
// Shared sizes and types of the palette lookup and allocate block.
// ----------------------------------------------------------------------------
package pla_pkg;

    // palette depth and derived widths
    localparam int PALETTE_ENTRIES = 256;
    localparam int ADDR_W          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
    localparam int LEVEL_W         = 8;
    localparam int COLOUR_W        = 3 * LEVEL_W;
    localparam int INDEX_W         = 8;

    // access to the palette memory, issued by the sequencer
    typedef struct packed {
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [COLOUR_W-1:0] wr_data;
    } t_mem_req;

endpackage
`default_nettype wire

### design/pla_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pla_ctrl
// Search sequencer: scans used palette entries one per cycle through a single
// comparator, then answers with the hit, an append or a full indication.
// ----------------------------------------------------------------------------
module pla_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pla_pkg::COLOUR_W-1:0]  i_colour,
    input  wire logic [pla_pkg::COLOUR_W-1:0]  i_rd_data,
    output pla_pkg::t_mem_req                  o_mem,
    output logic                               o_result_valid,
    output logic [pla_pkg::INDEX_W-1:0]        o_colour_index,
    output logic                               o_newly_added,
    output logic                               o_table_full
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [pla_pkg::CNT_W-1:0]       r_used, n_used;
    logic [pla_pkg::CNT_W-1:0]       r_addr, n_addr;
    logic [pla_pkg::ADDR_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                            r_cmp_vld, n_cmp_vld;
    logic [pla_pkg::COLOUR_W-1:0]    r_colour, n_colour;
    logic                            r_res_vld, n_res_vld;
    logic [pla_pkg::INDEX_W-1:0]     r_res_idx, n_res_idx;
    logic                            r_res_new, n_res_new;
    logic                            r_res_full, n_res_full;
    logic                            hit;
    logic                            issue;
    logic                            scan_done;
    logic                            is_full;

    // compare stage and issue stage conditions
    assign hit       = r_cmp_vld && (i_rd_data == r_colour);
    assign issue     = (r_addr < r_used);
    assign scan_done = !r_cmp_vld && !issue;
    assign is_full   = (r_used == pla_pkg::CNT_W'(pla_pkg::PALETTE_ENTRIES));

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_addr     = r_addr;
        n_cmp_idx  = r_cmp_idx;
        n_cmp_vld  = 1'b0;
        n_colour   = r_colour;
        n_res_vld  = 1'b0;
        n_res_idx  = r_res_idx;
        n_res_new  = r_res_new;
        n_res_full = r_res_full;
        o_mem      = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_colour = i_colour;
                    n_addr   = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // read the next used entry
                if (issue) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_addr[pla_pkg::ADDR_W-1:0];
                    n_cmp_idx     = r_addr[pla_pkg::ADDR_W-1:0];
                    n_cmp_vld     = 1'b1;
                    n_addr        = pla_pkg::CNT_W'(r_addr + 1'b1);
                end
                if (hit) begin
                    n_res_vld  = 1'b1;
                    n_res_idx  = pla_pkg::INDEX_W'(r_cmp_idx);
                    n_res_new  = 1'b0;
                    n_res_full = 1'b0;
                    n_cmp_vld  = 1'b0;
                    n_state    = S_IDLE;
                end else if (scan_done) begin
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (is_full) begin
                        n_res_idx  = '0;
                        n_res_new  = 1'b0;
                        n_res_full = 1'b1;
                    end else begin
                        // append at the next free entry
                        o_mem.wr_en   = 1'b1;
                        o_mem.wr_addr = r_used[pla_pkg::ADDR_W-1:0];
                        o_mem.wr_data = r_colour;
                        n_res_idx     = pla_pkg::INDEX_W'(r_used);
                        n_res_new     = 1'b1;
                        n_res_full    = 1'b0;
                        n_used        = pla_pkg::CNT_W'(r_used + 1'b1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_cmp_vld <= n_cmp_vld;
            r_res_vld <= n_res_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_cmp_idx  <= n_cmp_idx;
        r_colour   <= n_colour;
        r_res_idx  <= n_res_idx;
        r_res_new  <= n_res_new;
        r_res_full <= n_res_full;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_colour_index = r_res_idx;
    assign o_newly_added  = r_res_new;
    assign o_table_full   = r_res_full;

    // one result per request, never on consecutive cycles
    a_res_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |=> !r_res_vld)
        else $error("result strobe on consecutive cycles");

    // append and full are exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> !(r_res_new && r_res_full))
        else $error("newly added and table full together");

    // fill count stays within the palette
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= pla_pkg::CNT_W'(pla_pkg::PALETTE_ENTRIES))
        else $error("entry count beyond palette depth");

    // full answer carries index zero and only happens on a full table
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res_full) |-> (r_res_idx == '0 && is_full))
        else $error("bad table full answer");

    // an append always bumps the fill count
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |=> (r_used == pla_pkg::CNT_W'($past(r_used) + 1'b1)))
        else $error("append without count update");

endmodule
`default_nettype wire

### design/palette_lookup_allocate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// palette_lookup_allocate
// Colour palette lookup with append on miss, searched one entry per cycle.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The used entries are
// scanned lowest index first, one per cycle through the single read port of
// the palette memory. A hit ends the scan at that entry; a miss scans all
// used entries and then appends, or gives the full answer on a full palette,
// so a full 256-entry palette gives the longest search. Busy drops in the
// cycle the result strobe rises, and a new request may be taken then. The
// result is on the outputs for one cycle only, o_result_valid marks it and
// the receiver cannot hold it off. The palette memory has no reset and needs
// no clearing pass: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module palette_lookup_allocate (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [pla_pkg::LEVEL_W-1:0]  i_red_level,
    input  wire logic [pla_pkg::LEVEL_W-1:0]  i_green_level,
    input  wire logic [pla_pkg::LEVEL_W-1:0]  i_blue_level,
    output logic                              o_result_valid,
    output logic [pla_pkg::INDEX_W-1:0]       o_colour_index,
    output logic                              o_newly_added,
    output logic                              o_table_full
);

    logic [pla_pkg::COLOUR_W-1:0] r_mem [pla_pkg::PALETTE_ENTRIES];
    logic [pla_pkg::COLOUR_W-1:0] r_rd_data;
    logic [pla_pkg::COLOUR_W-1:0] colour;
    pla_pkg::t_mem_req            mem_req;

    // packed colour, red in the top byte
    assign colour = {i_red_level, i_green_level, i_blue_level};

    // palette memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_req.wr_en) begin
            r_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            r_rd_data <= r_mem[mem_req.rd_addr];
        end
    end

    // search sequencer
    pla_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_colour       (colour),
        .i_rd_data      (r_rd_data),
        .o_mem          (mem_req),
        .o_result_valid (o_result_valid),
        .o_colour_index (o_colour_index),
        .o_newly_added  (o_newly_added),
        .o_table_full   (o_table_full)
    );

endmodule
`default_nettype wire

### tb/sv/tb_palette_lookup_allocate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_lookup_allocate
// Self-checking testbench of the palette lookup and allocate block.
// ----------------------------------------------------------------------------
// Colour requests go in over the start/busy handshake. A local copy of the
// palette predicts each answer: the index of a hit, an append at the next free
// index, or the table-full answer. Every strobed answer is checked field by
// field against the oldest prediction. The run covers directed corner colours,
// a random mix of repeats, fresh and near-miss colours, and a full palette.
// ----------------------------------------------------------------------------
module tb_palette_lookup_allocate;

    localparam int ENTRIES  = pla_pkg::PALETTE_ENTRIES;
    localparam int LEVEL_W  = pla_pkg::LEVEL_W;
    localparam int COLOUR_W = pla_pkg::COLOUR_W;
    localparam int INDEX_W  = pla_pkg::INDEX_W;

    // expected answer of one colour request
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               added;
        logic               full;
    } t_answer;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic [LEVEL_W-1:0]  i_red_level   = '0;
    logic [LEVEL_W-1:0]  i_green_level = '0;
    logic [LEVEL_W-1:0]  i_blue_level  = '0;
    wire                 busy;
    wire                 o_result_valid;
    wire [INDEX_W-1:0]   o_colour_index;
    wire                 o_newly_added;
    wire                 o_table_full;

    // local copy of the palette contents
    logic [COLOUR_W-1:0] palette_copy [ENTRIES];
    int                  entries_filled = 0;
    t_answer             pending_answers [$];
    int                  mismatch_count = 0;
    bit                  gaps_enabled   = 1'b1;

    palette_lookup_allocate DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_red_level    (i_red_level),
        .i_green_level  (i_green_level),
        .i_blue_level   (i_blue_level),
        .o_result_valid (o_result_valid),
        .o_colour_index (o_colour_index),
        .o_newly_added  (o_newly_added),
        .o_table_full   (o_table_full)
    );

    always #4 i_clk = ~i_clk;

    // search, then append on miss while room is left
    function automatic t_answer lookup_or_append(input logic [COLOUR_W-1:0] colour);
        t_answer ans;
        ans = '0;
        for (int k = 0; k < entries_filled; k++) begin
            if (palette_copy[k] == colour) begin
                ans.index = INDEX_W'(k);
                return ans;
            end
        end
        if (entries_filled >= ENTRIES) begin
            ans.full = 1'b1;
            return ans;
        end
        palette_copy[entries_filled] = colour;
        ans.index = INDEX_W'(entries_filled);
        ans.added = 1'b1;
        entries_filled++;
        return ans;
    endfunction

    function automatic bit is_stored(input logic [COLOUR_W-1:0] colour);
        for (int k = 0; k < entries_filled; k++)
            if (palette_copy[k] == colour)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [COLOUR_W-1:0] unused_colour();
        logic [COLOUR_W-1:0] colour;
        do
            colour = COLOUR_W'($urandom());
        while (is_stored(colour));
        return colour;
    endfunction

    function automatic logic [COLOUR_W-1:0] stored_colour();
        return palette_copy[$urandom_range(entries_filled - 1)];
    endfunction

    // one colour request over the start/busy handshake
    task automatic send_request(input logic [COLOUR_W-1:0] colour);
        int gap;
        bit taken;
        // start is low here; right after an accept the block is already busy
        @(posedge i_clk);
        gap = 0;
        if (gaps_enabled && $urandom_range(99) < 28)
            gap = $urandom_range(1, 280);
        repeat (gap) @(posedge i_clk);
        start         <= 1'b1;
        i_red_level   <= colour[23:16];
        i_green_level <= colour[15:8];
        i_blue_level  <= colour[7:0];
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        start <= 1'b0;
        pending_answers.push_back(lookup_or_append(colour));
    endtask

    task automatic wait_for_answers();
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // answer checker, sampled mid-cycle while the strobe is stable
    always @(negedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_result_valid) begin
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected answer: index %0d added %0b full %0b",
                         $time, o_colour_index, o_newly_added, o_table_full);
            end else begin
                exp_ans = pending_answers.pop_front();
                if (o_colour_index !== exp_ans.index) begin
                    mismatch_count++;
                    $display("%0t colour_index: expected %0d actual %0d",
                             $time, exp_ans.index, o_colour_index);
                end
                if (o_newly_added !== exp_ans.added) begin
                    mismatch_count++;
                    $display("%0t newly_added: expected %0b actual %0b",
                             $time, exp_ans.added, o_newly_added);
                end
                if (o_table_full !== exp_ans.full) begin
                    mismatch_count++;
                    $display("%0t table_full: expected %0b actual %0b",
                             $time, exp_ans.full, o_table_full);
                end
            end
        end
    end

    // corner colours, first appends and repeats of them
    task automatic test_corner_colours();
        send_request(24'h000000);
        send_request(24'hFFFFFF);
        send_request(24'h000000);
        send_request(24'hFFFFFF);
        send_request(24'hFF0000);
        send_request(24'h00FF00);
        send_request(24'h0000FF);
        send_request(24'h800000);
        send_request(24'h008000);
        send_request(24'h000080);
        send_request(24'h010101);
        send_request(24'hAA55AA);
        send_request(24'h55AA55);
        send_request(24'hFEFFFF);
        send_request(24'hFFFFFE);
        send_request(24'h0000FF);
        send_request(24'h7F7F7F);
        send_request(24'h808080);
        send_request(24'hAA55AA);
        send_request(24'h000001);
        wait_for_answers();
    endtask

    // repeats of stored colours, fresh colours and one-bit near misses
    task automatic test_random_mix(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            gaps_enabled = !(n >= 100 && n < 200);
            pick = $urandom_range(99);
            if (pick < 35)
                send_request(stored_colour());
            else if (pick < 90)
                send_request(COLOUR_W'($urandom()));
            else
                send_request(stored_colour() ^ (COLOUR_W'(1) << $urandom_range(COLOUR_W - 1)));
            if (n == 250)
                wait_for_answers();
        end
        gaps_enabled = 1'b1;
        wait_for_answers();
    endtask

    // fill every entry, then hits on both ends and misses on a full palette
    task automatic test_full_palette(input int count);
        while (entries_filled < ENTRIES)
            send_request(unused_colour());
        wait_for_answers();
        send_request(palette_copy[0]);
        send_request(palette_copy[ENTRIES - 1]);
        send_request(unused_colour());
        send_request(palette_copy[ENTRIES - 1] ^ COLOUR_W'(1));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1))
                send_request(stored_colour());
            else
                send_request(unused_colour());
        end
        wait_for_answers();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_colours();
        test_random_mix(400);
        test_full_palette(40);
        repeat (300) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            mismatch_count++;
            $display("%0t %0d answers never arrived", $time, pending_answers.size());
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

### files.f
design/pla_pkg.sv
design/pla_ctrl.sv
design/palette_lookup_allocate.sv
tb/sv/tb_palette_lookup_allocate.sv
